>>> hw/rtl/ccg_pkg.sv
`default_nettype none

package ccg_pkg;

    // Field and accumulator widths.
    localparam int unsigned CUR_W  = 16;
    localparam int unsigned CAP_W  = 36;
    localparam int unsigned MV_W   = 16;
    localparam int unsigned SOC_W  = 7;
    localparam int unsigned NET_W  = 40;
    localparam int unsigned TOT_W  = 48;
    localparam int unsigned CYC_W  = 32;
    localparam int unsigned CFG_W  = 36;
    localparam int unsigned ADDR_W = 2;
    localparam int unsigned OUT_W  = 192;

    // Shared divider: remainder holds up to twice the capacity.
    localparam int unsigned DIV_W  = CAP_W + 1;
    localparam int unsigned NUM_W  = TOT_W;
    localparam int unsigned STEP_W = 6;

    // Quotient lengths of the three divisions.
    localparam logic [STEP_W-1:0] VOLT_STEPS  = STEP_W'(17);
    localparam logic [STEP_W-1:0] CYCLE_STEPS = STEP_W'(48);
    localparam logic [STEP_W-1:0] SOC_STEPS   = STEP_W'(7);

    localparam int unsigned SAMPLE_SECONDS_DEF = 1;
    localparam int unsigned SOC_SCALE          = 200;

    // Register reset values.
    localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(900000);
    localparam logic [MV_W-1:0]  FULL_MV_RST  = MV_W'(12600);
    localparam logic [MV_W-1:0]  EMPTY_MV_RST = MV_W'(11000);

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_FULL_MV  = 2'd1,
        CFG_EMPTY_MV = 2'd2
    } cfg_addr_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_MUL0,
        ST_MUL1,
        ST_VDIV,
        ST_VWAIT,
        ST_CDIV,
        ST_CWAIT,
        ST_SDIV,
        ST_SWAIT,
        ST_OUT
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem_init;
        logic [NUM_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } div_req_t;

    // Divider status and result.
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/ccg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller preloads the
// partial remainder (which must be below the divisor) and the remaining
// dividend bits, most significant first, and sets the number of steps.
module ccg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ccg_pkg::div_req_t req,
    output ccg_pkg::div_rsp_t      rsp
);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [ccg_pkg::STEP_W-1:0]   cnt_reg;
    logic [ccg_pkg::STEP_W-1:0]   cnt_next;
    logic [ccg_pkg::DIV_W-1:0]    rem_reg;
    logic [ccg_pkg::NUM_W-1:0]    num_reg;
    logic [ccg_pkg::NUM_W-1:0]    quot_reg;
    logic [ccg_pkg::DIV_W-1:0]    den_reg;

    logic [ccg_pkg::DIV_W:0]      trial;
    logic [ccg_pkg::DIV_W:0]      trial_diff;
    logic                         fits;

    // One subtract-and-compare step.
    always_comb
    begin
        trial      = {rem_reg, num_reg[ccg_pkg::NUM_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});
    end

    // Step counter and completion flag.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ccg_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            num_reg  <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_diff[ccg_pkg::DIV_W-1:0] : trial[ccg_pkg::DIV_W-1:0];
            num_reg  <= {num_reg[ccg_pkg::NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[ccg_pkg::NUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/coulomb_counter_cycle_gauge_top.sv
// An input transaction runs a partial-product multiply, then 17, 48 and 7 steps
// of the shared restoring divider, plus sequencing; the multiply and the voltage
// or charge division are skipped when voltage or charge is fixed.
// The block takes one sample at a time; the output register lets the next
// sample enter while a result still waits on the master side.
// Reset: rst_n clears accumulators, cycle count and control, and loads register defaults.
`default_nettype none

module coulomb_counter_cycle_gauge_top #(
    parameter int unsigned SAMPLE_SECONDS = ccg_pkg::SAMPLE_SECONDS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ccg_pkg::ADDR_W-1:0]     cfg_addr,
    input  wire logic [ccg_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // [15:0] sample_ma
    input  wire logic [ccg_pkg::CUR_W-1:0]      s_axis_tdata,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [6:0] soc_percent, [22:7] voltage_mv, [62:23] net_discharge,
    // [110:63] total_out, [158:111] total_in, [190:159] full_cycles,
    // [191] cycle_added
    output      logic [ccg_pkg::OUT_W-1:0]      m_axis_tdata
);

    localparam int unsigned SecW = $clog2(SAMPLE_SECONDS + 1);
    localparam int unsigned MagW = ccg_pkg::CUR_W + 1;
    localparam int unsigned QW   = MagW + SecW;
    localparam int unsigned LoW  = 18;
    localparam int unsigned PartW = ccg_pkg::MV_W + LoW;
    localparam int unsigned ProdW = ccg_pkg::MV_W + ccg_pkg::CAP_W;
    localparam int unsigned VNumW = ProdW + 2;
    localparam int unsigned SNumW = ccg_pkg::CAP_W + 9;

    // Configuration registers.
    logic [ccg_pkg::CAP_W-1:0]  cap_cfg_reg;
    logic [ccg_pkg::MV_W-1:0]   full_mv_reg;
    logic [ccg_pkg::MV_W-1:0]   empty_mv_reg;

    // Sequencer.
    ccg_pkg::state_t            state_reg;
    ccg_pkg::state_t            state_next;

    // Working registers.
    logic [ccg_pkg::CUR_W-1:0]  cur_reg;
    logic [ccg_pkg::CAP_W-1:0]  cap_reg;
    logic [ccg_pkg::CAP_W-1:0]  vnet_reg;
    logic [ccg_pkg::MV_W-1:0]   diff_reg;
    logic [ProdW-1:0]           prod_reg;
    logic [ccg_pkg::MV_W-1:0]   volt_reg;
    logic [ccg_pkg::SOC_W-1:0]  soc_reg;
    logic                       added_reg;

    // Accumulators.
    logic [ccg_pkg::NET_W-1:0]  net_reg;
    logic [ccg_pkg::TOT_W-1:0]  tout_reg;
    logic [ccg_pkg::TOT_W-1:0]  tin_reg;
    logic [ccg_pkg::CYC_W-1:0]  cyc_reg;

    // Output register.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ccg_pkg::OUT_W-1:0]  out_data_reg;

    logic                       in_fire;
    logic                       out_load;
    logic [ccg_pkg::CAP_W-1:0]  cap_eff;
    logic                       cur_neg;
    logic [MagW-1:0]            cur_mag;
    logic [QW-1:0]              charge;
    logic [ccg_pkg::NET_W:0]    net_sum;
    logic [ccg_pkg::NET_W-1:0]  net_upd;
    logic [ccg_pkg::TOT_W:0]    tout_sum;
    logic [ccg_pkg::TOT_W:0]    tin_sum;
    logic                       net_ge_cap;
    logic                       net_gt_cap;
    logic [LoW-1:0]             mul_sel;
    logic [PartW-1:0]           part_prod;
    logic [VNumW-1:0]           vnum;
    logic [SNumW-1:0]           snum;
    logic [ccg_pkg::CAP_W-1:0]  soc_left;
    logic [ccg_pkg::MV_W-1:0]   term;
    logic [ccg_pkg::CYC_W-1:0]  cyc_expected;
    ccg_pkg::div_req_t          div_req;
    ccg_pkg::div_rsp_t          div_rsp;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg  <= ccg_pkg::CAPACITY_RST;
            full_mv_reg  <= ccg_pkg::FULL_MV_RST;
            empty_mv_reg <= ccg_pkg::EMPTY_MV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ccg_pkg::CFG_CAPACITY: cap_cfg_reg  <= cfg_data[ccg_pkg::CAP_W-1:0];
                ccg_pkg::CFG_FULL_MV:  full_mv_reg  <= cfg_data[ccg_pkg::MV_W-1:0];
                ccg_pkg::CFG_EMPTY_MV: empty_mv_reg <= cfg_data[ccg_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Charge of one sample and the saturating accumulator updates.
    always_comb
    begin
        cap_eff    = (cap_cfg_reg == '0) ? ccg_pkg::CAP_W'(1) : cap_cfg_reg;
        cur_neg    = cur_reg[ccg_pkg::CUR_W-1];
        cur_mag    = cur_neg ? (MagW'(1) << ccg_pkg::CUR_W) - {1'b0, cur_reg}
                             : {1'b0, cur_reg};
        charge     = QW'(cur_mag) * QW'(SAMPLE_SECONDS);
        net_sum    = {1'b0, net_reg} + (ccg_pkg::NET_W + 1)'(charge);
        if (cur_neg)
        begin
            net_upd = net_sum[ccg_pkg::NET_W] ? '1 : net_sum[ccg_pkg::NET_W-1:0];
        end
        else
        begin
            net_upd = (net_reg > ccg_pkg::NET_W'(charge))
                    ? net_reg - ccg_pkg::NET_W'(charge) : '0;
        end
        tout_sum   = {1'b0, tout_reg} + (cur_neg ? (ccg_pkg::TOT_W + 1)'(charge) : '0);
        tin_sum    = {1'b0, tin_reg} + (cur_neg ? '0 : (ccg_pkg::TOT_W + 1)'(charge));
        net_ge_cap = (net_reg >= ccg_pkg::NET_W'(cap_reg));
        net_gt_cap = (net_reg > ccg_pkg::NET_W'(cap_reg));
    end

    // Shared partial-product multiplier: low half of the net discharge first, then high half.
    always_comb
    begin
        mul_sel   = (state_reg == ccg_pkg::ST_MUL1) ? vnet_reg[ccg_pkg::CAP_W-1:LoW]
                                                    : vnet_reg[LoW-1:0];
        part_prod = PartW'(diff_reg) * PartW'(mul_sel);
    end

    // Dividend setup and result unpacking for the shared divider.
    always_comb
    begin
        vnum         = {1'b0, prod_reg, 1'b0} + VNumW'(cap_reg);
        soc_left     = cap_reg - net_reg[ccg_pkg::CAP_W-1:0];
        snum         = SNumW'(soc_left) * SNumW'(ccg_pkg::SOC_SCALE) + SNumW'(cap_reg);
        term         = div_rsp.quot[ccg_pkg::MV_W-1:0];
        cyc_expected = (div_rsp.quot[ccg_pkg::TOT_W-1:ccg_pkg::CYC_W] != '0)
                     ? '1 : div_rsp.quot[ccg_pkg::CYC_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccg_pkg::ST_IDLE:  if (in_fire) state_next = ccg_pkg::ST_UPD;
            ccg_pkg::ST_UPD:   state_next = net_ge_cap ? ccg_pkg::ST_CDIV : ccg_pkg::ST_MUL0;
            ccg_pkg::ST_MUL0:  state_next = ccg_pkg::ST_MUL1;
            ccg_pkg::ST_MUL1:  state_next = ccg_pkg::ST_VDIV;
            ccg_pkg::ST_VDIV:  state_next = ccg_pkg::ST_VWAIT;
            ccg_pkg::ST_VWAIT: if (div_rsp.done) state_next = ccg_pkg::ST_CDIV;
            ccg_pkg::ST_CDIV:  state_next = ccg_pkg::ST_CWAIT;
            ccg_pkg::ST_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = net_gt_cap ? ccg_pkg::ST_OUT : ccg_pkg::ST_SDIV;
                end
            end
            ccg_pkg::ST_SDIV:  state_next = ccg_pkg::ST_SWAIT;
            ccg_pkg::ST_SWAIT: if (div_rsp.done) state_next = ccg_pkg::ST_OUT;
            ccg_pkg::ST_OUT:   if (out_load) state_next = ccg_pkg::ST_IDLE;
            default:           state_next = ccg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and divider requests.
    always_comb
    begin
        s_axis_tready    = (state_reg == ccg_pkg::ST_IDLE);
        in_fire          = s_axis_tvalid && (state_reg == ccg_pkg::ST_IDLE);
        out_load         = (state_reg == ccg_pkg::ST_OUT) && (!out_valid_reg || m_axis_tready);
        div_req.start    = 1'b0;
        div_req.steps    = ccg_pkg::CYCLE_STEPS;
        div_req.rem_init = '0;
        div_req.num      = tout_reg;
        div_req.den      = {1'b0, cap_reg};
        unique case (state_reg)
            ccg_pkg::ST_VDIV:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = ccg_pkg::VOLT_STEPS;
                div_req.rem_init = vnum[VNumW-1:17];
                div_req.num      = {vnum[16:0], (ccg_pkg::NUM_W - 17)'(0)};
                div_req.den      = {cap_reg, 1'b0};
            end
            ccg_pkg::ST_CDIV:
            begin
                div_req.start = 1'b1;
            end
            ccg_pkg::ST_SDIV:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = ccg_pkg::SOC_STEPS;
                div_req.rem_init = snum[SNumW-2:7];
                div_req.num      = {snum[6:0], (ccg_pkg::NUM_W - 7)'(0)};
                div_req.den      = {cap_reg, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Accumulators and cycle count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_reg  <= '0;
            tout_reg <= '0;
            tin_reg  <= '0;
            cyc_reg  <= '0;
        end
        else
        begin
            if (state_reg == ccg_pkg::ST_UPD)
            begin
                net_reg  <= net_upd;
                tout_reg <= tout_sum[ccg_pkg::TOT_W] ? '1 : tout_sum[ccg_pkg::TOT_W-1:0];
                tin_reg  <= tin_sum[ccg_pkg::TOT_W] ? '1 : tin_sum[ccg_pkg::TOT_W-1:0];
            end
            if ((state_reg == ccg_pkg::ST_CWAIT) && div_rsp.done && (cyc_expected > cyc_reg))
            begin
                cyc_reg <= cyc_expected;
            end
        end
    end

    // Working registers of one sample.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg <= s_axis_tdata;
            cap_reg <= cap_eff;
        end
        unique case (state_reg)
            ccg_pkg::ST_UPD:
            begin
                // Voltage is taken from the net discharge before this sample.
                vnet_reg <= net_reg[ccg_pkg::CAP_W-1:0];
                diff_reg <= (full_mv_reg >= empty_mv_reg) ? full_mv_reg - empty_mv_reg
                                                          : empty_mv_reg - full_mv_reg;
                if (net_ge_cap)
                begin
                    volt_reg <= empty_mv_reg;
                end
            end
            ccg_pkg::ST_MUL0:
            begin
                prod_reg <= ProdW'(part_prod);
            end
            ccg_pkg::ST_MUL1:
            begin
                prod_reg <= prod_reg + {part_prod, LoW'(0)};
            end
            ccg_pkg::ST_VWAIT:
            begin
                if (div_rsp.done)
                begin
                    volt_reg <= (full_mv_reg >= empty_mv_reg) ? full_mv_reg - term
                                                              : full_mv_reg + term;
                end
            end
            ccg_pkg::ST_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    added_reg <= (cyc_expected > cyc_reg);
                    if (net_gt_cap)
                    begin
                        soc_reg <= '0;
                    end
                end
            end
            ccg_pkg::ST_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    soc_reg <= div_rsp.quot[ccg_pkg::SOC_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {added_reg, cyc_reg, tin_reg, tout_reg, net_reg,
                             volt_reg, soc_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Shared divider for voltage, cycle count and state of charge.
    ccg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ccg_checker.sv
`default_nettype none

module ccg_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [ccg_pkg::OUT_W-1:0]  m_axis_tdata
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // State of charge never exceeds full.
    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd100))
        else $error("state of charge above 100 percent");

    // A raised cycle count is never zero.
    a_cycle_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[191] |-> (m_axis_tdata[190:159] != 32'd0))
        else $error("cycle flag set with zero cycle count");

endmodule

bind coulomb_counter_cycle_gauge_top ccg_checker u_ccg_checker (.*);

`default_nettype wire

>>> sim/tb_coulomb_counter_cycle_gauge_top.sv
`default_nettype none

module tb_coulomb_counter_cycle_gauge_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLE_S       = ccg_pkg::SAMPLE_SECONDS_DEF;
    localparam int unsigned ITEM_TARGET    = 1950;
    localparam int unsigned QUIET_ITEMS    = 150;
    localparam int unsigned SQUEEZE_PHASE  = 3;
    localparam int unsigned SQUEEZE_CYCLES = 2000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned WATCHDOG_LIMIT = 10000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [ccg_pkg::ADDR_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [63:0] NET_FULL = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [63:0] TOT_FULL = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] CYC_FULL = 64'h0000_0000_FFFF_FFFF;
    localparam logic [ccg_pkg::CAP_W-1:0] CAP_MAX = {ccg_pkg::CAP_W{1'b1}};

    // One result, laid out exactly as m_axis_tdata packs it.
    typedef struct packed {
        logic                      cycle_added;
        logic [ccg_pkg::CYC_W-1:0] full_cycles;
        logic [ccg_pkg::TOT_W-1:0] total_in;
        logic [ccg_pkg::TOT_W-1:0] total_out;
        logic [ccg_pkg::NET_W-1:0] net_discharge;
        logic [ccg_pkg::MV_W-1:0]  voltage_mv;
        logic [ccg_pkg::SOC_W-1:0] soc_percent;
    } gauge_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [ccg_pkg::ADDR_W-1:0] addr;
        logic [ccg_pkg::CFG_W-1:0]  data;
        logic [ccg_pkg::CUR_W-1:0]  current;
        gauge_result_t              known;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ccg_pkg::ADDR_W-1:0] cfg_addr = '0;
    logic [ccg_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [ccg_pkg::CUR_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [ccg_pkg::OUT_W-1:0] m_axis_tdata;

    // Shadow copy of the registers and the gauge state.
    logic [ccg_pkg::CAP_W-1:0] cap_shadow;
    logic [ccg_pkg::MV_W-1:0]  full_mv_shadow;
    logic [ccg_pkg::MV_W-1:0]  empty_mv_shadow;
    logic [ccg_pkg::NET_W-1:0] net_acc;
    logic [ccg_pkg::TOT_W-1:0] out_acc;
    logic [ccg_pkg::TOT_W-1:0] in_acc;
    logic [ccg_pkg::CYC_W-1:0] cycle_cnt;

    gauge_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int unsigned samples_sent = 0;
    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    bit          quiet_tail = 1'b0;
    bit          tx_idle_en = 1'b1;
    bit          squeeze_req = 1'b0;

    coulomb_counter_cycle_gauge_top #(
        .SAMPLE_SECONDS(SAMPLE_S)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advances the shadow gauge by one current sample and returns its result.
    function automatic gauge_result_t gauge_step(input logic [ccg_pkg::CUR_W-1:0] current);
        logic [63:0] cap;
        logic [63:0] diff;
        logic [63:0] term;
        logic [63:0] charge;
        logic [63:0] sum;
        logic [63:0] volt;
        logic [63:0] cycles;
        logic [63:0] soc;
        gauge_result_t res;
        cap = (cap_shadow == '0) ? 64'd1 : 64'(cap_shadow);

        // Voltage uses the net discharge from before this sample.
        if (64'(net_acc) >= cap)
            volt = 64'(empty_mv_shadow);
        else
        begin
            diff = (full_mv_shadow >= empty_mv_shadow) ?
                   64'(full_mv_shadow - empty_mv_shadow) :
                   64'(empty_mv_shadow - full_mv_shadow);
            term = (64'd2 * diff * 64'(net_acc) + cap) / (64'd2 * cap);
            volt = (full_mv_shadow >= empty_mv_shadow) ? 64'(full_mv_shadow) - term :
                                                         64'(full_mv_shadow) + term;
        end

        // Discharge adds to both net and total out; charge clips net at zero.
        if (current[ccg_pkg::CUR_W-1])
        begin
            charge = (64'd65536 - 64'(current)) * 64'(SAMPLE_S);
            sum = 64'(net_acc) + charge;
            net_acc = (sum > NET_FULL) ? NET_FULL[ccg_pkg::NET_W-1:0]
                                       : sum[ccg_pkg::NET_W-1:0];
            sum = 64'(out_acc) + charge;
            out_acc = (sum > TOT_FULL) ? TOT_FULL[ccg_pkg::TOT_W-1:0]
                                       : sum[ccg_pkg::TOT_W-1:0];
        end
        else if (current != '0)
        begin
            charge = 64'(current) * 64'(SAMPLE_S);
            net_acc = (64'(net_acc) > charge) ? ccg_pkg::NET_W'(64'(net_acc) - charge) : '0;
            sum = 64'(in_acc) + charge;
            in_acc = (sum > TOT_FULL) ? TOT_FULL[ccg_pkg::TOT_W-1:0]
                                      : sum[ccg_pkg::TOT_W-1:0];
        end

        // Cycle count follows floor(total out / capacity) but never falls.
        cycles = 64'(out_acc) / cap;
        if (cycles > CYC_FULL)
            cycles = CYC_FULL;
        res.cycle_added = 1'b0;
        if (cycles > 64'(cycle_cnt))
        begin
            cycle_cnt = cycles[ccg_pkg::CYC_W-1:0];
            res.cycle_added = 1'b1;
        end

        if (64'(net_acc) > cap)
            soc = 64'd0;
        else
            soc = (64'd200 * (cap - 64'(net_acc)) + cap) / (64'd2 * cap);

        res.soc_percent   = soc[ccg_pkg::SOC_W-1:0];
        res.voltage_mv    = volt[ccg_pkg::MV_W-1:0];
        res.net_discharge = net_acc;
        res.total_out     = out_acc;
        res.total_in      = in_acc;
        res.full_cycles   = cycle_cnt;
        return res;
    endfunction

    // Random current sample; drain_pct sets how often a sample discharges.
    function automatic logic [ccg_pkg::CUR_W-1:0] pick_current(input int unsigned drain_pct);
        int unsigned sel;
        logic [ccg_pkg::CUR_W-1:0] mag;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        if (sel < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        if (sel < 25)
            return ccg_pkg::CUR_W'($urandom);
        mag = (sel < 55) ? ccg_pkg::CUR_W'($urandom_range(1, 32767))
                         : ccg_pkg::CUR_W'($urandom_range(1, 1023));
        return ($urandom_range(0, 99) < drain_pct) ? -mag : mag;
    endfunction

    function automatic stim_row_t cfg_row(input logic [ccg_pkg::ADDR_W-1:0] addr,
                                          input logic [ccg_pkg::CFG_W-1:0] data);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.addr = addr;
        row.data = data;
        row.current = '0;
        row.known = '0;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input logic [ccg_pkg::CUR_W-1:0] current);
        stim_row_t row;
        row = cfg_row(ccg_pkg::CFG_CAPACITY, '0);
        row.kind = ROW_SAMPLE;
        row.current = current;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [ccg_pkg::CUR_W-1:0] current,
                                            input logic [ccg_pkg::SOC_W-1:0] soc,
                                            input logic [ccg_pkg::MV_W-1:0] mv,
                                            input logic [ccg_pkg::NET_W-1:0] net,
                                            input logic [ccg_pkg::TOT_W-1:0] tot_out,
                                            input logic [ccg_pkg::TOT_W-1:0] tot_in);
        stim_row_t row;
        row = sample_row(current);
        row.kind = ROW_KNOWN;
        row.known.soc_percent = soc;
        row.known.voltage_mv = mv;
        row.known.net_discharge = net;
        row.known.total_out = tot_out;
        row.known.total_in = tot_in;
        row.known.full_cycles = '0;
        row.known.cycle_added = 1'b0;
        return row;
    endfunction

    // Writes one register once every result is out and the block is idle.
    task automatic write_reg(input logic [ccg_pkg::ADDR_W-1:0] addr,
                             input logic [ccg_pkg::CFG_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            ccg_pkg::CFG_CAPACITY: cap_shadow = data[ccg_pkg::CAP_W-1:0];
            ccg_pkg::CFG_FULL_MV:  full_mv_shadow = data[ccg_pkg::MV_W-1:0];
            ccg_pkg::CFG_EMPTY_MV: empty_mv_shadow = data[ccg_pkg::MV_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one sample, waits for its transaction, then records the expected result.
    task automatic send_sample(input logic [ccg_pkg::CUR_W-1:0] current, input bit use_known,
                               input gauge_result_t known);
        gauge_result_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= current;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = gauge_step(current);
        pending_results.push_back(use_known ? known : predicted);
        samples_sent++;
        if (!quiet_tail && tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Stimulus: reset, directed table, then random phases with their own settings.
    initial
    begin
        int unsigned phase;
        int unsigned phase_len;
        int unsigned drain_pct;
        int unsigned sel;
        logic [ccg_pkg::CAP_W-1:0] cap_val;
        logic [ccg_pkg::MV_W-1:0] mv_val;
        phase = 0;

        cap_shadow = ccg_pkg::CAPACITY_RST;
        full_mv_shadow = ccg_pkg::FULL_MV_RST;
        empty_mv_shadow = ccg_pkg::EMPTY_MV_RST;
        net_acc = '0;
        out_acc = '0;
        in_acc = '0;
        cycle_cnt = '0;

        // Default settings straight after reset.
        directed_rows.push_back(known_row(16'h0000, 7'd100, 16'd12600, 40'd0, 48'd0, 48'd0));
        directed_rows.push_back(known_row(16'h8000, 7'd96, 16'd12600, 40'd32768,
                                          48'd32768, 48'd0));
        directed_rows.push_back(known_row(16'h7FFF, 7'd100, 16'd12542, 40'd1,
                                          48'd32768, 48'd32767));
        // Charging past zero net discharge clips it.
        directed_rows.push_back(known_row(16'h7FFF, 7'd100, 16'd12600, 40'd0,
                                          48'd32768, 48'd65534));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(sample_row(16'h0001));
        directed_rows.push_back(sample_row(16'h5555));
        directed_rows.push_back(sample_row(16'hAAAA));
        // A small capacity: state of charge saturates and cycles count up.
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_CAPACITY, 36'd20000));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h7FFF));
        directed_rows.push_back(sample_row(16'h0000));
        // Zero capacity behaves as a capacity of one.
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_CAPACITY, 36'd0));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(sample_row(16'h7FFF));
        directed_rows.push_back(sample_row(16'h0000));
        // Largest capacity with empty voltage above full voltage.
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_CAPACITY, CAP_MAX));
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_FULL_MV, 36'd0));
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_EMPTY_MV, 36'd65535));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h0000));
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_FULL_MV, 36'd65535));
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_EMPTY_MV, 36'd0));
        directed_rows.push_back(sample_row(16'h8000));
        directed_rows.push_back(sample_row(16'h7FFF));
        // A write to the unused index changes nothing.
        directed_rows.push_back(cfg_row(CFG_SPARE, CAP_MAX));
        directed_rows.push_back(sample_row(16'h0000));
        // Equal full and empty voltages.
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_FULL_MV, 36'd1234));
        directed_rows.push_back(cfg_row(ccg_pkg::CFG_EMPTY_MV, 36'd1234));
        directed_rows.push_back(sample_row(16'hFFFF));
        directed_rows.push_back(sample_row(16'h8001));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            else
                send_sample(directed_rows[i].current, directed_rows[i].kind == ROW_KNOWN,
                            directed_rows[i].known);
        end

        // Random phases: new settings, a discharge bias, then a run of samples.
        while (samples_sent < ITEM_TARGET)
        begin
            // Settings only change before the tail, which runs without gaps.
            if (samples_sent + QUIET_ITEMS < ITEM_TARGET)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    sel = $urandom_range(0, 15);
                    case (sel)
                        0: cap_val = '0;
                        1: cap_val = 36'd1;
                        2: cap_val = CAP_MAX;
                        3: cap_val = {4'($urandom_range(0, 15)), 32'($urandom)};
                        4, 5: cap_val = ccg_pkg::CAPACITY_RST;
                        6, 7, 8, 9: cap_val = ccg_pkg::CAP_W'($urandom_range(20000, 100000));
                        default: cap_val = ccg_pkg::CAP_W'($urandom_range(100000, 1000000));
                    endcase
                    write_reg(ccg_pkg::CFG_CAPACITY, cap_val);
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: mv_val = '0;
                        1: mv_val = '1;
                        2: mv_val = ccg_pkg::FULL_MV_RST;
                        default: mv_val = ccg_pkg::MV_W'($urandom);
                    endcase
                    write_reg(ccg_pkg::CFG_FULL_MV, {20'($urandom), mv_val});
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: mv_val = '0;
                        1: mv_val = '1;
                        2: mv_val = ccg_pkg::EMPTY_MV_RST;
                        default: mv_val = ccg_pkg::MV_W'($urandom);
                    endcase
                    write_reg(ccg_pkg::CFG_EMPTY_MV, {20'($urandom), mv_val});
                end
                if ($urandom_range(0, 15) == 0)
                    write_reg(CFG_SPARE, ccg_pkg::CFG_W'($urandom));
            end

            case ($urandom_range(0, 3))
                0: drain_pct = 30;
                1: drain_pct = 50;
                2: drain_pct = 70;
                default: drain_pct = 90;
            endcase
            tx_idle_en = ($urandom_range(0, 9) < 7);
            phase_len = (phase == SQUEEZE_PHASE) ? 60 : $urandom_range(20, 120);
            // The receiver holds off during this phase while samples keep coming.
            if (phase == SQUEEZE_PHASE)
                squeeze_req = 1'b1;
            for (int unsigned k = 0; k < phase_len && samples_sent < ITEM_TARGET; k++)
            begin
                quiet_tail = (samples_sent + QUIET_ITEMS >= ITEM_TARGET);
                send_sample(pick_current(drain_pct), 1'b0, '0);
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain and decide.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, calm stretches and a quiet tail.
    initial
    begin
        int unsigned stall_left;
        int unsigned rx_cycle;
        bit squeeze_done;
        stall_left = 0;
        rx_cycle = 0;
        squeeze_done = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                stall_left = SQUEEZE_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_tail && ((rx_cycle / 700) % 3 != 0) && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected result.
    always @(posedge clk)
    begin
        gauge_result_t got;
        gauge_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = gauge_result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: soc=%0d mv=%0d net=%0d",
                             got.soc_percent, got.voltage_mv, got.net_discharge);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.soc_percent !== want.soc_percent ||
                    got.voltage_mv !== want.voltage_mv ||
                    got.net_discharge !== want.net_discharge ||
                    got.total_out !== want.total_out ||
                    got.total_in !== want.total_in ||
                    got.full_cycles !== want.full_cycles ||
                    got.cycle_added !== want.cycle_added)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch exp: soc=%0d mv=%0d net=%0d out=%0d in=%0d cyc=%0d add=%0d",
                                 want.soc_percent, want.voltage_mv, want.net_discharge,
                                 want.total_out, want.total_in, want.full_cycles,
                                 want.cycle_added);
                        $display("         got: soc=%0d mv=%0d net=%0d out=%0d in=%0d cyc=%0d add=%0d",
                                 got.soc_percent, got.voltage_mv, got.net_discharge,
                                 got.total_out, got.total_in, got.full_cycles,
                                 got.cycle_added);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction and no register write.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire
